[hw/rtl/lrmb_pkg.sv]
// Shared types and constants of the line raster max-blend core.
// Depends on nothing; every other file of the block but lrmb_ram imports it.
`default_nettype none

package lrmb_pkg;

   // Field widths
   localparam int COORD_W    = 6;
   localparam int LEVEL_W    = 8;
   localparam int COLOR_W    = 8;
   localparam int PANEL_W    = 7;
   localparam int FUNC_W     = 2;
   localparam int DIM_W      = 10;   // signed target coordinates and panel sizes
   localparam int ERR_W      = 9;    // Bresenham error term, signed
   localparam int PROD_W     = COLOR_W + LEVEL_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_RED    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_GREEN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_BLUE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PANEL_WIDTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PANEL_HEIGHT = 3'd4;

   typedef enum logic [FUNC_W-1:0] {
      OP_CLEAR = 2'd0,
      OP_DRAW  = 2'd1,
      OP_READ  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   // Command as classified by the front
   typedef struct packed {
      op_type                   op;
      logic [COORD_W-1:0]       x0;
      logic [COORD_W-1:0]       y0;
      logic [COORD_W-1:0]       x1;
      logic [COORD_W-1:0]       y1;
      logic [COORD_W-1:0]       dx;
      logic [COORD_W-1:0]       dy;
      logic                     sx;   // 1: step +1, 0: step -1
      logic                     sy;
      logic signed [ERR_W-1:0]  err0;
      logic [LEVEL_W-1:0]       level;
      logic                     halo;
      logic                     include_end;
   } cmd_type;

   // Configuration as seen by the back
   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic [DIM_W-1:0]   eff_width;
      logic [DIM_W-1:0]   eff_height;
   } cfg_type;

   // Queue status toward front and back
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

`default_nettype wire

[hw/rtl/line_raster_max_blend_core.sv]
// Top level of the line raster max-blend core: configuration registers,
// front, command queue and back. Depends on lrmb_pkg, lrmb_front,
// lrmb_queue and lrmb_back (which holds the lrmb_ram pixel store).
//
//   channel | ports                        | moves
//   --------+------------------------------+--------------------------------------
//   req     | req_valid / req_ready        | one command per transfer
//   rsp     | rsp_valid / rsp_ready        | one result per command, in order
//   csr     | csr_we, csr_index, csr_wdata | one register write per cycle, no wait
//
// Sequence: a read fetches the level from the store and scales the colour by it; a
// pixel outside the panel skips the store. A clear sweeps the whole store. A draw
// reads and max-blends each target pixel inside the panel in turn, up to 5 blended
// pixels per line pixel with halo.
// Reset: synchronous; afterwards the store is zeroed by a sweep over all
// MAX_WIDTH*MAX_HEIGHT words (4096 by default) with req_ready low.
// Stalls: a two-entry queue takes commands while the back works, and the result
// register holds a finished result until it is taken.
`default_nettype none

module line_raster_max_blend_core #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [lrmb_pkg::FUNC_W-1:0]      req_func,
   input  logic [lrmb_pkg::COORD_W-1:0]     req_x_start,
   input  logic [lrmb_pkg::COORD_W-1:0]     req_y_start,
   input  logic [lrmb_pkg::COORD_W-1:0]     req_x_end,
   input  logic [lrmb_pkg::COORD_W-1:0]     req_y_end,
   input  logic [lrmb_pkg::LEVEL_W-1:0]     req_level,
   input  logic                             req_halo,
   input  logic                             req_include_end,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [lrmb_pkg::COLOR_W-1:0]     rsp_red,
   output logic [lrmb_pkg::COLOR_W-1:0]     rsp_green,
   output logic [lrmb_pkg::COLOR_W-1:0]     rsp_blue,
   output logic [lrmb_pkg::LEVEL_W-1:0]     rsp_stored_level,
   input  logic                             csr_we,
   input  logic [lrmb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lrmb_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import lrmb_pkg::*;

   logic [COLOR_W-1:0] color_red_ff;
   logic [COLOR_W-1:0] color_green_ff;
   logic [COLOR_W-1:0] color_blue_ff;
   logic [PANEL_W-1:0] panel_width_ff;
   logic [PANEL_W-1:0] panel_height_ff;
   logic [DIM_W-1:0]   width_ext;
   logic [DIM_W-1:0]   height_ext;

   cfg_type            cfg;
   cmd_type            push_cmd;
   cmd_type            pop_cmd;
   qstat_type          q_stat;
   logic               push;
   logic               pop;
   logic               init_busy;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         color_red_ff    <= COLOR_W'(255);
         color_green_ff  <= COLOR_W'(255);
         color_blue_ff   <= COLOR_W'(255);
         panel_width_ff  <= PANEL_W'(64);
         panel_height_ff <= PANEL_W'(32);
      end else if (csr_we) begin
         case (csr_index)
            CSR_COLOR_RED:    color_red_ff    <= csr_wdata[COLOR_W-1:0];
            CSR_COLOR_GREEN:  color_green_ff  <= csr_wdata[COLOR_W-1:0];
            CSR_COLOR_BLUE:   color_blue_ff   <= csr_wdata[COLOR_W-1:0];
            CSR_PANEL_WIDTH:  panel_width_ff  <= csr_wdata[PANEL_W-1:0];
            CSR_PANEL_HEIGHT: panel_height_ff <= csr_wdata[PANEL_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the panel size to the store
   assign width_ext  = {{(DIM_W-PANEL_W){1'b0}}, panel_width_ff};
   assign height_ext = {{(DIM_W-PANEL_W){1'b0}}, panel_height_ff};

   always_comb begin
      cfg.red        = color_red_ff;
      cfg.green      = color_green_ff;
      cfg.blue       = color_blue_ff;
      cfg.eff_width  = (width_ext > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_ext;
      cfg.eff_height = (height_ext > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_ext;
   end

   lrmb_front u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_x_start     (req_x_start),
      .req_y_start     (req_y_start),
      .req_x_end       (req_x_end),
      .req_y_end       (req_y_end),
      .req_level       (req_level),
      .req_halo        (req_halo),
      .req_include_end (req_include_end),
      .q_stat          (q_stat),
      .init_busy       (init_busy),
      .push            (push),
      .cmd             (push_cmd)
   );

   lrmb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .stat     (q_stat)
   );

   lrmb_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .q_stat           (q_stat),
      .q_cmd            (pop_cmd),
      .q_pop            (pop),
      .init_busy        (init_busy),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_stored_level (rsp_stored_level)
   );

endmodule

`default_nettype wire

[hw/rtl/lrmb_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
`default_nettype none

module lrmb_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/lrmb_front.sv]
// Front of the core: input handshake and command classification.
// Depends on lrmb_pkg; feeds lrmb_queue.
`default_nettype none

module lrmb_front (
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [lrmb_pkg::FUNC_W-1:0]   req_func,
   input  logic [lrmb_pkg::COORD_W-1:0]  req_x_start,
   input  logic [lrmb_pkg::COORD_W-1:0]  req_y_start,
   input  logic [lrmb_pkg::COORD_W-1:0]  req_x_end,
   input  logic [lrmb_pkg::COORD_W-1:0]  req_y_end,
   input  logic [lrmb_pkg::LEVEL_W-1:0]  req_level,
   input  logic                          req_halo,
   input  logic                          req_include_end,
   input  lrmb_pkg::qstat_type           q_stat,
   input  logic                          init_busy,
   output logic                          push,
   output lrmb_pkg::cmd_type             cmd
);

   import lrmb_pkg::*;

   logic [COORD_W-1:0] dx;
   logic [COORD_W-1:0] dy;

   // Accept while the queue has room and the reset sweep is over
   assign req_ready = !q_stat.full && !init_busy;
   assign push      = req_valid && req_ready;

   // Line setup: deltas, step directions and initial error
   assign dx = (req_x_end >= req_x_start) ? req_x_end - req_x_start
                                          : req_x_start - req_x_end;
   assign dy = (req_y_end >= req_y_start) ? req_y_end - req_y_start
                                          : req_y_start - req_y_end;

   always_comb begin
      cmd.op          = op_type'(req_func);
      cmd.x0          = req_x_start;
      cmd.y0          = req_y_start;
      cmd.x1          = req_x_end;
      cmd.y1          = req_y_end;
      cmd.dx          = dx;
      cmd.dy          = dy;
      cmd.sx          = req_x_start < req_x_end;
      cmd.sy          = req_y_start < req_y_end;
      cmd.err0        = $signed({{(ERR_W-COORD_W){1'b0}}, dx})
                      - $signed({{(ERR_W-COORD_W){1'b0}}, dy});
      cmd.level       = req_level;
      cmd.halo        = req_halo;
      cmd.include_end = req_include_end;
   end

endmodule

`default_nettype wire

[hw/rtl/lrmb_queue.sv]
// Short command queue between the front and the back.
// Depends on lrmb_pkg.
`default_nettype none

module lrmb_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lrmb_pkg::cmd_type   push_cmd,
   input  logic                pop,
   output lrmb_pkg::cmd_type   pop_cmd,
   output lrmb_pkg::qstat_type stat
);

   import lrmb_pkg::*;

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;

   assign stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/lrmb_back.sv]
// Back of the core: clear sweep, Bresenham walk with read-modify-write
// blending, pixel read with colour scaling and the result register.
// Depends on lrmb_pkg and lrmb_ram.
`default_nettype none

module lrmb_back #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lrmb_pkg::cfg_type             cfg,
   input  lrmb_pkg::qstat_type           q_stat,
   input  lrmb_pkg::cmd_type             q_cmd,
   output logic                          q_pop,
   output logic                          init_busy,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lrmb_pkg::COLOR_W-1:0]  rsp_red,
   output logic [lrmb_pkg::COLOR_W-1:0]  rsp_green,
   output logic [lrmb_pkg::COLOR_W-1:0]  rsp_blue,
   output logic [lrmb_pkg::LEVEL_W-1:0]  rsp_stored_level
);

   import lrmb_pkg::*;

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int E_W    = ERR_W + 1;

   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_CLEAR   = 9'b000000010,
      S_PIX     = 9'b000000100,
      S_TGT     = 9'b000001000,
      S_BLEND   = 9'b000010000,
      S_STEP    = 9'b000100000,
      S_RD_ADDR = 9'b001000000,
      S_RD_DATA = 9'b010000000,
      S_RESP    = 9'b100000000
   } state_type;

   typedef enum logic [2:0] {
      NBR_CENTER = 3'd0,
      NBR_LEFT   = 3'd1,
      NBR_RIGHT  = 3'd2,
      NBR_UP     = 3'd3,
      NBR_DOWN   = 3'd4
   } nbr_type;

   // Exact floor(p / 255) for p up to 255 * 255
   function automatic logic [COLOR_W-1:0] div255(input logic [PROD_W-1:0] p);
      logic [PROD_W:0] sum;
      sum = {1'b0, p} + {{(COLOR_W + 1){1'b0}}, p[PROD_W-1:COLOR_W]} + 1'b1;
      return sum[PROD_W-1:COLOR_W];
   endfunction

   state_type              state_ff, state_in;
   cmd_type                cmd_ff, cmd_in;
   logic [COORD_W-1:0]     x_ff, x_in;
   logic [COORD_W-1:0]     y_ff, y_in;
   logic signed [ERR_W-1:0] err_ff, err_in;
   nbr_type                nbr_ff, nbr_in;
   logic [ADDR_W-1:0]      tgt_addr_ff, tgt_addr_in;
   logic [LEVEL_W-1:0]     tgt_lvl_ff, tgt_lvl_in;
   logic [ADDR_W-1:0]      clr_cnt_ff, clr_cnt_in;
   logic                   init_ff, init_in;
   logic [PROD_W-1:0]      prod_r_ff, prod_r_in;
   logic [PROD_W-1:0]      prod_g_ff, prod_g_in;
   logic [PROD_W-1:0]      prod_b_ff, prod_b_in;
   logic [LEVEL_W-1:0]     lvl_s_ff, lvl_s_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [COLOR_W-1:0]     rsp_red_ff, rsp_red_in;
   logic [COLOR_W-1:0]     rsp_green_ff, rsp_green_in;
   logic [COLOR_W-1:0]     rsp_blue_ff, rsp_blue_in;
   logic [LEVEL_W-1:0]     rsp_lvl_ff, rsp_lvl_in;

   logic signed [DIM_W-1:0] tx, ty;
   logic [DIM_W-1:0]        tx_u, ty_u;
   logic                    in_panel;
   logic [ADDR_W-1:0]       tgt_addr;
   logic [LEVEL_W-1:0]      tgt_lvl;
   logic                    at_end;
   logic                    last_tgt;
   nbr_type                 nbr_next;
   logic                    do_plot;
   state_type               plot_done_state;

   logic signed [E_W-1:0]   e2, dx_s, dy_s;
   logic                    step_x, step_y;

   logic                    ram_wr_en;
   logic [ADDR_W-1:0]       ram_wr_addr;
   logic [LEVEL_W-1:0]      ram_wr_data;
   logic                    ram_rd_en;
   logic [LEVEL_W-1:0]      ram_rd_data;

   lrmb_ram #(
      .DATA_W (LEVEL_W),
      .DEPTH  (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (tgt_addr),
      .rd_data (ram_rd_data)
   );

   // Target pixel: current line pixel or one of its four neighbors
   always_comb begin
      tx = $signed({{(DIM_W-COORD_W){1'b0}}, x_ff});
      ty = $signed({{(DIM_W-COORD_W){1'b0}}, y_ff});
      unique case (nbr_ff)
         NBR_CENTER: ;
         NBR_LEFT:   tx = tx - $signed(DIM_W'(1));
         NBR_RIGHT:  tx = tx + $signed(DIM_W'(1));
         NBR_UP:     ty = ty - $signed(DIM_W'(1));
         NBR_DOWN:   ty = ty + $signed(DIM_W'(1));
         default:    ;
      endcase
   end

   assign tx_u     = tx;
   assign ty_u     = ty;
   assign in_panel = !tx[DIM_W-1] && !ty[DIM_W-1]
                   && (tx_u < cfg.eff_width) && (ty_u < cfg.eff_height);
   assign tgt_addr = ADDR_W'(ADDR_W'(ty_u) * ADDR_W'(MAX_WIDTH) + ADDR_W'(tx_u));
   assign tgt_lvl  = (nbr_ff == NBR_CENTER) ? cmd_ff.level : (cmd_ff.level >> 1);

   // Neighbor sequencing and end-of-line decisions
   always_comb begin
      unique case (nbr_ff)
         NBR_CENTER: nbr_next = NBR_LEFT;
         NBR_LEFT:   nbr_next = NBR_RIGHT;
         NBR_RIGHT:  nbr_next = NBR_UP;
         NBR_UP:     nbr_next = NBR_DOWN;
         default:    nbr_next = NBR_CENTER;
      endcase
   end

   assign at_end          = (x_ff == cmd_ff.x1) && (y_ff == cmd_ff.y1);
   assign last_tgt        = (nbr_ff == NBR_DOWN) || ((nbr_ff == NBR_CENTER) && !cmd_ff.halo);
   assign do_plot         = !at_end || cmd_ff.include_end
                          || ((cmd_ff.dx == '0) && (cmd_ff.dy == '0));
   assign plot_done_state = at_end ? S_RESP : S_STEP;

   // Bresenham step decisions
   assign e2     = $signed({err_ff, 1'b0});
   assign dx_s   = $signed({{(E_W-COORD_W){1'b0}}, cmd_ff.dx});
   assign dy_s   = $signed({{(E_W-COORD_W){1'b0}}, cmd_ff.dy});
   assign step_x = e2 > -dy_s;
   assign step_y = e2 < dx_s;

   // Memory port control
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = tgt_addr_ff;
      ram_wr_data = tgt_lvl_ff;
      ram_rd_en   = 1'b0;
      if (state_ff == S_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_cnt_ff;
         ram_wr_data = '0;
      end else if (state_ff == S_BLEND) begin
         ram_wr_en = ram_rd_data < tgt_lvl_ff;
      end
      if ((state_ff == S_TGT) || (state_ff == S_RD_ADDR)) begin
         ram_rd_en = in_panel;
      end
   end

   assign q_pop = (state_ff == S_IDLE) && !q_stat.empty;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      err_in       = err_ff;
      nbr_in       = nbr_ff;
      tgt_addr_in  = tgt_addr_ff;
      tgt_lvl_in   = tgt_lvl_ff;
      clr_cnt_in   = clr_cnt_ff;
      init_in      = init_ff;
      prod_r_in    = prod_r_ff;
      prod_g_in    = prod_g_ff;
      prod_b_in    = prod_b_ff;
      lvl_s_in     = lvl_s_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_red_in   = rsp_red_ff;
      rsp_green_in = rsp_green_ff;
      rsp_blue_in  = rsp_blue_ff;
      rsp_lvl_in   = rsp_lvl_ff;

      // drop the result once the transfer completes
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (!q_stat.empty) begin
               cmd_in     = q_cmd;
               x_in       = q_cmd.x0;
               y_in       = q_cmd.y0;
               err_in     = q_cmd.err0;
               nbr_in     = NBR_CENTER;
               clr_cnt_in = '0;
               prod_r_in  = '0;
               prod_g_in  = '0;
               prod_b_in  = '0;
               lvl_s_in   = '0;
               unique case (q_cmd.op)
                  OP_CLEAR: state_in = S_CLEAR;
                  OP_DRAW:  state_in = S_PIX;
                  OP_READ:  state_in = S_RD_ADDR;
                  default:  state_in = S_RESP;
               endcase
            end
         end
         S_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == ADDR_W'(DEPTH - 1)) begin
               init_in  = 1'b0;
               state_in = init_ff ? S_IDLE : S_RESP;
            end
         end
         S_PIX: begin
            nbr_in   = NBR_CENTER;
            state_in = do_plot ? S_TGT : S_RESP;
         end
         S_TGT: begin
            tgt_addr_in = tgt_addr;
            tgt_lvl_in  = tgt_lvl;
            if (in_panel) begin
               state_in = S_BLEND;
            end else if (last_tgt) begin
               state_in = plot_done_state;
            end else begin
               nbr_in = nbr_next;
            end
         end
         S_BLEND: begin
            if (last_tgt) begin
               state_in = plot_done_state;
            end else begin
               nbr_in   = nbr_next;
               state_in = S_TGT;
            end
         end
         S_STEP: begin
            err_in = ERR_W'(err_ff - (step_x ? ERR_W'(cmd_ff.dy) : ERR_W'(0))
                                   + (step_y ? ERR_W'(cmd_ff.dx) : ERR_W'(0)));
            if (step_x) begin
               x_in = cmd_ff.sx ? x_ff + 1'b1 : x_ff - 1'b1;
            end
            if (step_y) begin
               y_in = cmd_ff.sy ? y_ff + 1'b1 : y_ff - 1'b1;
            end
            state_in = S_PIX;
         end
         S_RD_ADDR: begin
            state_in = in_panel ? S_RD_DATA : S_RESP;
         end
         S_RD_DATA: begin
            prod_r_in = PROD_W'(cfg.red) * PROD_W'(ram_rd_data);
            prod_g_in = PROD_W'(cfg.green) * PROD_W'(ram_rd_data);
            prod_b_in = PROD_W'(cfg.blue) * PROD_W'(ram_rd_data);
            lvl_s_in  = ram_rd_data;
            state_in  = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_red_in   = div255(prod_r_ff);
               rsp_green_in = div255(prod_g_ff);
               rsp_blue_in  = div255(prod_b_ff);
               rsp_lvl_in   = lvl_s_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control state; reset starts the clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         init_ff      <= 1'b1;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      err_ff       <= err_in;
      nbr_ff       <= nbr_in;
      tgt_addr_ff  <= tgt_addr_in;
      tgt_lvl_ff   <= tgt_lvl_in;
      prod_r_ff    <= prod_r_in;
      prod_g_ff    <= prod_g_in;
      prod_b_ff    <= prod_b_in;
      lvl_s_ff     <= lvl_s_in;
      rsp_red_ff   <= rsp_red_in;
      rsp_green_ff <= rsp_green_in;
      rsp_blue_ff  <= rsp_blue_in;
      rsp_lvl_ff   <= rsp_lvl_in;
   end

   assign init_busy        = init_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_red          = rsp_red_ff;
   assign rsp_green        = rsp_green_ff;
   assign rsp_blue         = rsp_blue_ff;
   assign rsp_stored_level = rsp_lvl_ff;

endmodule

`default_nettype wire
